// ===== hw/rtl/fst_pkg.sv =====
`timescale 1ns / 1ps

package fst_pkg;

    // Table geometry.
    localparam int MAX_SEGMENTS = 16;
    localparam int SEG_IDX_W    = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = 5;

    // Item function codes.
    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_LOOKUP = 2'd1;
    localparam logic [1:0] FUNC_SIZE   = 2'd2;
    localparam logic [1:0] FUNC_SPLIT  = 2'd3;

    // One segment table entry.
    typedef struct packed {
        logic [7:0]  region;
        logic [31:0] start;
        logic [31:0] length;
        logic [31:0] phys;
        logic [7:0]  page_rd;
        logic [7:0]  page_wr;
    } seg_entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_entry;
        logic start_job;
        logic read_entry;
        logic check_entry;
        logic next_entry;
        logic emit_lookup;
        logic emit_chunk;
        logic advance;
        logic emit_final;
    } fst_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] job_func;
        logic       no_entries;
        logic       zero_length;
        logic       hit;
        logic       last_entry;
        logic       chunk_ends;
        logic       out_free;
    } fst_status_t;

endpackage

// ===== hw/rtl/fst_datapath.sv =====
`timescale 1ns / 1ps

module fst_datapath
    import fst_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  fst_cmd_t           cmd,
    output fst_status_t        status,
    input  logic               cfg_we,
    input  logic [CNT_W-1:0]   cfg_data,
    input  logic [1:0]         func,
    input  logic [3:0]         entry_index,
    input  logic [7:0]         region_id,
    input  logic [31:0]        region_offset,
    input  logic [31:0]        read_length,
    input  logic [7:0]         seg_region,
    input  logic [31:0]        seg_start,
    input  logic [31:0]        seg_length,
    input  logic [31:0]        seg_phys,
    input  logic [7:0]         seg_page_rd,
    input  logic [7:0]         seg_page_wr,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               ok,
    output logic [31:0]        phys_addr,
    output logic [7:0]         page_read,
    output logic [7:0]         page_write,
    output logic [31:0]        chunk_len,
    output logic [31:0]        dest_offset,
    output logic [31:0]        region_size,
    output logic               last
);

    seg_entry_t seg_mem [MAX_SEGMENTS];
    seg_entry_t ent_q;

    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic [CNT_W-1:0]     n_eff;
    logic [1:0]           func_reg, func_next;
    logic [7:0]           region_reg, region_next;
    logic [32:0]          off_reg, off_next;
    logic [31:0]          remain_reg, remain_next;
    logic [31:0]          done_reg, done_next;
    logic [31:0]          sum_reg, sum_next;
    logic                 found_reg, found_next;
    logic [SEG_IDX_W-1:0] idx_reg, idx_next;
    logic [32:0]          diff_reg, diff_next;
    logic [31:0]          chunk_reg, chunk_next;

    logic        ov_reg, ov_next;
    logic        ok_reg, ok_next;
    logic [31:0] phys_reg, phys_next;
    logic [7:0]  prd_reg, prd_next;
    logic [7:0]  pwr_reg, pwr_next;
    logic [31:0] clen_reg, clen_next;
    logic [31:0] doff_reg, doff_next;
    logic [31:0] rsize_reg, rsize_next;
    logic        last_reg, last_next;

    logic [32:0] start_ext;
    logic [32:0] end_ext;
    logic [32:0] diff;
    logic        match;
    logic        hit;
    logic [32:0] sum_ext;
    logic [31:0] avail;
    logic [31:0] chunk;
    logic [31:0] phys_sum;
    logic        out_free;

    // Table memory: written by load items, read into the entry register by the walk.
    always_ff @(posedge clk)
    begin
        if (cmd.load_entry)
        begin
            seg_mem[SEG_IDX_W'(entry_index)] <= '{region:  seg_region,
                                                  start:   seg_start,
                                                  length:  seg_length,
                                                  phys:    seg_phys,
                                                  page_rd: seg_page_rd,
                                                  page_wr: seg_page_wr};
        end
        if (cmd.read_entry)
        begin
            ent_q <= seg_mem[idx_reg];
        end
    end

    // Counts above the table depth act as the full table.
    assign n_eff = (cnt_reg > CNT_W'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS) : cnt_reg;

    // Coverage test on the entry just read, with the offset at 33 bits.
    assign start_ext = {1'b0, ent_q.start};
    assign end_ext   = start_ext + {1'b0, ent_q.length};
    assign diff      = off_reg - start_ext;
    assign match     = (ent_q.region == region_reg);
    assign hit       = match && (off_reg >= start_ext) && (off_reg < end_ext);
    assign sum_ext   = {1'b0, sum_reg} + {1'b0, ent_q.length};

    // Chunk sizing uses the registered distance into the entry.
    assign avail    = ent_q.length - diff_reg[31:0];
    assign chunk    = (remain_reg < avail) ? remain_reg : avail;
    assign phys_sum = ent_q.phys + diff_reg[31:0];
    assign out_free = !ov_reg || out_ready;

    always_comb
    begin
        cnt_next    = cfg_we ? cfg_data : cnt_reg;
        func_next   = func_reg;
        region_next = region_reg;
        off_next    = off_reg;
        remain_next = remain_reg;
        done_next   = done_reg;
        sum_next    = sum_reg;
        found_next  = found_reg;
        idx_next    = idx_reg;
        diff_next   = diff_reg;
        chunk_next  = chunk_reg;

        if (cmd.start_job)
        begin
            func_next   = func;
            region_next = region_id;
            off_next    = {1'b0, region_offset};
            remain_next = read_length;
            done_next   = '0;
            sum_next    = '0;
            found_next  = 1'b0;
            idx_next    = '0;
        end
        if (cmd.check_entry)
        begin
            diff_next = diff;
            if (func_reg == FUNC_SIZE && match)
            begin
                found_next = 1'b1;
                sum_next   = sum_ext[32] ? 32'hFFFF_FFFF : sum_ext[31:0];
            end
        end
        if (cmd.emit_chunk)
        begin
            chunk_next = chunk;
        end
        if (cmd.advance)
        begin
            off_next    = off_reg + {1'b0, chunk_reg};
            done_next   = done_reg + chunk_reg;
            remain_next = remain_reg - chunk_reg;
        end
        if (cmd.next_entry)
        begin
            idx_next = idx_reg + SEG_IDX_W'(1);
        end
    end

    // Output register.
    always_comb
    begin
        ov_next    = ov_reg && !out_ready;
        ok_next    = ok_reg;
        phys_next  = phys_reg;
        prd_next   = prd_reg;
        pwr_next   = pwr_reg;
        clen_next  = clen_reg;
        doff_next  = doff_reg;
        rsize_next = rsize_reg;
        last_next  = last_reg;

        if (cmd.emit_lookup || cmd.emit_chunk || cmd.emit_final)
        begin
            ov_next    = 1'b1;
            ok_next    = 1'b0;
            phys_next  = '0;
            prd_next   = '0;
            pwr_next   = '0;
            clen_next  = '0;
            doff_next  = '0;
            rsize_next = '0;
            last_next  = 1'b0;
            if (cmd.emit_lookup)
            begin
                ok_next   = 1'b1;
                phys_next = phys_sum;
                prd_next  = ent_q.page_rd;
                pwr_next  = ent_q.page_wr;
                last_next = 1'b1;
            end
            else if (cmd.emit_chunk)
            begin
                ok_next   = 1'b1;
                phys_next = phys_sum;
                prd_next  = ent_q.page_rd;
                clen_next = chunk;
                doff_next = done_reg;
            end
            else
            begin
                last_next = 1'b1;
                case (func_reg)
                    FUNC_SIZE:
                    begin
                        ok_next    = found_reg;
                        rsize_next = sum_reg;
                    end
                    FUNC_SPLIT:
                    begin
                        ok_next   = (remain_reg == '0);
                        doff_next = done_reg;
                    end
                    default:
                    begin
                        ok_next = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        region_reg <= region_next;
        off_reg    <= off_next;
        remain_reg <= remain_next;
        done_reg   <= done_next;
        sum_reg    <= sum_next;
        found_reg  <= found_next;
        idx_reg    <= idx_next;
        diff_reg   <= diff_next;
        chunk_reg  <= chunk_next;
        ok_reg     <= ok_next;
        phys_reg   <= phys_next;
        prd_reg    <= prd_next;
        pwr_reg    <= pwr_next;
        clen_reg   <= clen_next;
        doff_reg   <= doff_next;
        rsize_reg  <= rsize_next;
        last_reg   <= last_next;
    end

    assign status.job_func    = func_reg;
    assign status.no_entries  = (n_eff == '0);
    assign status.zero_length = (read_length == '0);
    assign status.hit         = hit;
    assign status.last_entry  = (CNT_W'(idx_reg) == n_eff - CNT_W'(1));
    assign status.chunk_ends  = (chunk_reg == remain_reg);
    assign status.out_free    = out_free;

    assign out_valid   = ov_reg;
    assign ok          = ok_reg;
    assign phys_addr   = phys_reg;
    assign page_read   = prd_reg;
    assign page_write  = pwr_reg;
    assign chunk_len   = clen_reg;
    assign dest_offset = doff_reg;
    assign region_size = rsize_reg;
    assign last        = last_reg;

endmodule

// ===== hw/rtl/fst_ctrl.sv =====
`timescale 1ns / 1ps

module fst_ctrl
    import fst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [1:0]  in_func,
    input  fst_status_t status,
    output fst_cmd_t    cmd,
    output logic        in_ready
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_func == FUNC_LOAD)
                    begin
                        cmd.load_entry = 1'b1;
                    end
                    else
                    begin
                        cmd.start_job = 1'b1;
                        if (status.no_entries ||
                            (in_func == FUNC_SPLIT && status.zero_length))
                        begin
                            state_next = S_FIN;
                        end
                        else
                        begin
                            state_next = S_RD;
                        end
                    end
                end
            end
            S_RD:
            begin
                cmd.read_entry = 1'b1;
                state_next     = S_CHK;
            end
            S_CHK:
            begin
                cmd.check_entry = 1'b1;
                if (status.hit && status.job_func != FUNC_SIZE)
                begin
                    state_next = S_EMIT;
                end
                else if (status.last_entry)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.next_entry = 1'b1;
                    state_next     = S_RD;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    if (status.job_func == FUNC_LOOKUP)
                    begin
                        cmd.emit_lookup = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        cmd.emit_chunk = 1'b1;
                        state_next     = S_UPD;
                    end
                end
            end
            S_UPD:
            begin
                cmd.advance = 1'b1;
                if (status.chunk_ends || status.last_entry)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.next_entry = 1'b1;
                    state_next     = S_RD;
                end
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.emit_final = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

// ===== hw/rtl/flash_segment_translator.sv =====
`timescale 1ns / 1ps

// Channel    Direction  Handshake              Contents
// input      in         in_valid / in_ready    func, entry_index, region query, segment fields
// output     out        out_valid / out_ready  ok, phys_addr, pages, chunk, offsets, size, last
// config     in         cfg_we (no wait)       cfg_data = entry_count
//
// A load item writes one table entry. A query walks at most the first entry_count
// entries of the table, each in a registered table read and a coverage check, and
// every chunk a read split emits adds an emit step and an offset advance step.
// Reset clears the state machine, the entry count and the output valid; the table
// itself is not cleared. A stalled output holds the walk at the next result.
module flash_segment_translator
    import fst_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       func,
    input  logic [3:0]       entry_index,
    input  logic [7:0]       region_id,
    input  logic [31:0]      region_offset,
    input  logic [31:0]      read_length,
    input  logic [7:0]       seg_region,
    input  logic [31:0]      seg_start,
    input  logic [31:0]      seg_length,
    input  logic [31:0]      seg_phys,
    input  logic [7:0]       seg_page_rd,
    input  logic [7:0]       seg_page_wr,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             ok,
    output logic [31:0]      phys_addr,
    output logic [7:0]       page_read,
    output logic [7:0]       page_write,
    output logic [31:0]      chunk_len,
    output logic [31:0]      dest_offset,
    output logic [31:0]      region_size,
    output logic             last
);

    fst_cmd_t    cmd;
    fst_status_t status;

    // The controller sequences the table walk; it sees only in_valid, func and the status.
    fst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_func  (func),
        .status   (status),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    // The datapath holds the table, the walk registers and the output register.
    fst_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .func          (func),
        .entry_index   (entry_index),
        .region_id     (region_id),
        .region_offset (region_offset),
        .read_length   (read_length),
        .seg_region    (seg_region),
        .seg_start     (seg_start),
        .seg_length    (seg_length),
        .seg_phys      (seg_phys),
        .seg_page_rd   (seg_page_rd),
        .seg_page_wr   (seg_page_wr),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .ok            (ok),
        .phys_addr     (phys_addr),
        .page_read     (page_read),
        .page_write    (page_write),
        .chunk_len     (chunk_len),
        .dest_offset   (dest_offset),
        .region_size   (region_size),
        .last          (last)
    );

`ifndef SYNTHESIS
    // A result that is not the final one is always a non-empty chunk.
    a_chunk_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> ok && (chunk_len != '0))
        else $error("intermediate result without a chunk");

    // A failed lookup, size query or split always closes its item.
    a_fail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> last)
        else $error("failing result not marked last");

    // The closing result carries no chunk length.
    a_last_no_chunk: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> chunk_len == '0)
        else $error("closing result carries a chunk length");

    // Results never appear in the cycle right after an item is taken.
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result raised straight after accepting an item");
`endif

endmodule
